[src/stb_pkg.sv]
// Shared types and constants for the square transposition buffer.
// No dependencies; every other file of the block but stb_ram imports this package.
package stb_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_W = 4;
    localparam logic [BYTE_W-1:0] BLANK_CELL = 8'h20;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store;       // input byte transfer: write or drop it
        logic start_emit;  // last byte taken: rewind the column walk
        logic read_first;  // fetch the first cell of the walk
        logic advance;     // cell taken: step the walk and fetch the next
        logic finish;      // final cell taken: clear the message state
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_cell;   // cell on the output is the last of the square
    } dp_status_t;

endpackage

[src/square_transposition_buffer.sv]
// Top level of the square transposition buffer.
// Depends on stb_pkg, stb_ctrl, stb_datapath (and through it stb_ram).
//
// Message bytes arrive on the slave stream and fill a square of side S row by
// row, S being the side register clamped into 1..MAX_SIDE (zero acts as one).
// Bytes past S*S are dropped and the overflow flag is raised for the message.
// The transfer marked tlast closes the message: the block then sends all S*S
// cells column by column, unfilled cells as spaces, with tlast on the final
// cell and tuser carrying the overflow flag on every cell. The slave stream is
// ready throughout loading. Emission first fetches the first cell from the
// single-port grid RAM in the prime state, then sends one cell per cycle while
// the sink is ready; the one RAM port is shared between writing bytes and
// reading cells. No input is taken while a square is being primed or sent. The
// grid needs no clearing pass after reset: the fill count masks cells not
// written by the current message. Write the side only between messages.
module square_transposition_buffer
    import stb_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration: side of the square
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    // message stream in
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,    // [7:0] msg_byte
    input  logic              s_tlast,    // msg_last
    // transposed stream out
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,    // [7:0] out_byte
    output logic              m_tlast,    // out_last
    output logic              m_tuser     // [0] overflowed
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequence load, prime and send; drive both handshakes
    stb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the grid, the fill count and the column walk
    stb_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_byte     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_byte    (m_tdata),
        .out_last    (m_tlast),
        .overflowed  (m_tuser)
    );

endmodule

[src/stb_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module stb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/stb_ctrl.sv]
// Controller of the square transposition buffer: load, prime and send phases.
// Depends on stb_pkg for the command and status structs.
module stb_ctrl
    import stb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        LOAD,
        PRIME,
        SEND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_xfer;
    logic   out_xfer;

    assign s_tready = (state_reg == LOAD);
    assign m_tvalid = (state_reg == SEND);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        cmd.store      = in_xfer;
        cmd.start_emit = in_xfer && s_tlast;
        cmd.read_first = (state_reg == PRIME);
        cmd.advance    = out_xfer && !status.last_cell;
        cmd.finish     = out_xfer && status.last_cell;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LOAD:
            begin
                if (in_xfer && s_tlast)
                begin
                    state_next = PRIME;
                end
            end
            PRIME:
            begin
                state_next = SEND;
            end
            SEND:
            begin
                if (out_xfer && status.last_cell)
                begin
                    state_next = LOAD;
                end
            end
            default:
            begin
                state_next = LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/stb_datapath.sv]
// Datapath of the square transposition buffer: side register, fill count,
// drop flag, column walk and the grid RAM. Depends on stb_pkg and stb_ram.
module stb_datapath
    import stb_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic [BYTE_W-1:0] in_byte,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last,
    output logic              overflowed
);

    localparam int unsigned CELLS = MAX_SIDE * MAX_SIDE;
    localparam int unsigned SW_RAW = $clog2(MAX_SIDE + 1);
    localparam int unsigned SW = (SW_RAW > CFG_W) ? SW_RAW : CFG_W;
    localparam int unsigned CW = 2 * SW;
    localparam int unsigned FW = $clog2(CELLS + 1);
    localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int unsigned RW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam logic [SW-1:0] MAX_SIDE_V = SW'(MAX_SIDE);
    localparam logic [SW-1:0] ONE_SIDE = SW'(1);

    logic [SW-1:0]     side_reg;
    logic [FW-1:0]     fill_reg;
    logic              drop_reg;
    logic [RW-1:0]     row_reg;
    logic [RW-1:0]     col_reg;
    logic [AW-1:0]     pos_reg;

    logic [SW-1:0]     eff_side;
    logic [SW-1:0]     side_m1;
    logic [CW-1:0]     cap;
    logic              room;
    logic              row_end;
    logic              col_end;
    logic [AW-1:0]     pos_next;
    logic [CW-1:0]     pos_step;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              shown;

    // Clamp the side into 1..MAX_SIDE
    always_comb
    begin
        if (side_reg == '0)
        begin
            eff_side = ONE_SIDE;
        end
        else if (side_reg > MAX_SIDE_V)
        begin
            eff_side = MAX_SIDE_V;
        end
        else
        begin
            eff_side = side_reg;
        end
    end

    assign side_m1 = eff_side - ONE_SIDE;
    assign cap     = CW'(eff_side) * CW'(eff_side);
    assign room    = CW'(fill_reg) < cap;
    assign row_end = SW'(row_reg) == side_m1;
    assign col_end = SW'(col_reg) == side_m1;

    // Step down the column; at its foot move to the top of the next column
    assign pos_step = CW'(pos_reg) + CW'(eff_side);
    always_comb
    begin
        if (row_end)
        begin
            pos_next = AW'(col_reg) + AW'(1);
        end
        else
        begin
            pos_next = pos_step[AW-1:0];
        end
    end

    assign ram_we   = cmd.store && room;
    assign ram_re   = cmd.read_first || cmd.advance;
    always_comb
    begin
        if (cmd.store)
        begin
            ram_addr = fill_reg[AW-1:0];
        end
        else if (cmd.advance)
        begin
            ram_addr = pos_next;
        end
        else
        begin
            ram_addr = pos_reg;
        end
    end

    stb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (in_byte),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= MAX_SIDE_V;
            fill_reg <= '0;
            drop_reg <= 1'b0;
            row_reg  <= '0;
            col_reg  <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                side_reg <= SW'(cfg_wr_data);
            end
            if (cmd.store)
            begin
                if (room)
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.start_emit)
            begin
                row_reg <= '0;
                col_reg <= '0;
                pos_reg <= '0;
            end
            else if (cmd.advance)
            begin
                pos_reg <= pos_next;
                if (row_end)
                begin
                    row_reg <= '0;
                    col_reg <= col_reg + RW'(1);
                end
                else
                begin
                    row_reg <= row_reg + RW'(1);
                end
            end
            if (cmd.finish)
            begin
                fill_reg <= '0;
                drop_reg <= 1'b0;
            end
        end
    end

    // A cell past the bytes of this message shows as a space
    assign shown            = FW'(pos_reg) < fill_reg;
    assign out_byte         = shown ? ram_rdata : BLANK_CELL;
    assign out_last         = row_end && col_end;
    assign overflowed       = drop_reg;
    assign status.last_cell = row_end && col_end;

endmodule

[dv/tb_square_transposition_buffer.sv]
// Self-checking testbench for square_transposition_buffer: bytes in, transposed cells out.
// Depends on stb_pkg and the block's RTL only; it carries its own predictor of the transpose.
`timescale 1ns / 1ps

module tb_square_transposition_buffer;
    import stb_pkg::*;

    localparam int unsigned MAX_SIDE       = 8;
    localparam int unsigned CELLS          = MAX_SIDE * MAX_SIDE;
    localparam int unsigned RANDOM_BYTES   = 50;
    localparam int unsigned SETTLE_CYCLES  = 4;     // block idle after the final cell
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles without any transfer

    // One transposed cell as the master stream presents it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              ovf;
    } cell_t;

    // Directed stimulus: either a side write or one message byte. Rows marked
    // typed carry the single cell of a side-one square, written out by hand.
    typedef enum logic {ROW_SIDE, ROW_BYTE} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              typed;
        logic [BYTE_W-1:0] typed_byte;
        logic              typed_ovf;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        // side from reset (8): one byte, then 63 blank cells
        '{ROW_BYTE, 8'h41, 1'b1, 1'b0, 8'h00, 1'b0},
        // side one: a single cell
        '{ROW_SIDE, 8'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0},
        // side one, grid already full when the last byte arrives: it is dropped
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'h5A, 1'b1, 1'b1, 8'h00, 1'b1},
        // side zero acts as side one
        '{ROW_SIDE, 8'd0,  1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'h80, 1'b1, 1'b1, 8'h80, 1'b0},
        // side fifteen acts as the largest side
        '{ROW_SIDE, 8'd15, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'h02, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'h7F, 1'b1, 1'b0, 8'h00, 1'b0},
        // side two: exact fill, then one byte too many
        '{ROW_SIDE, 8'd2,  1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'h10, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'h11, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'h12, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'h13, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'hA0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'hA1, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'hA2, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'hA3, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'hA4, 1'b1, 1'b0, 8'h00, 1'b0},
        // side three, partly filled
        '{ROW_SIDE, 8'd3,  1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'hC3, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, 8'h3C, 1'b1, 1'b0, 8'h00, 1'b0}
    };

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata     = '0;   // [7:0] msg_byte
    logic              s_tlast     = 1'b0; // msg_last
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [BYTE_W-1:0] m_tdata;            // [7:0] out_byte
    logic              m_tlast;            // out_last
    logic              m_tuser;            // [0] overflowed

    // Predictor state: its own copy of the side register, grid and message state
    logic [CFG_W-1:0]  side_reg_copy = CFG_W'(MAX_SIDE);
    logic [BYTE_W-1:0] grid_copy [CELLS];
    int unsigned       bytes_held = 0;
    logic              spill_seen = 1'b0;

    cell_t             expected_cells [$];

    int unsigned       error_count    = 0;
    int unsigned       bytes_sent     = 0;
    int unsigned       messages_sent  = 0;
    int unsigned       cells_checked  = 0;
    int unsigned       spilled_cells  = 0;
    logic [15:0]       sides_written  = '0;
    logic              steady_phase   = 1'b0;  // no sender gaps, no new sink stalls
    int unsigned       sink_hold      = 0;
    int unsigned       quiet_cycles   = 0;

    square_transposition_buffer #(
        .MAX_SIDE(MAX_SIDE)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int clamped_side(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return int'(v);
    endfunction

    // Store or drop one byte; on the closing byte queue every cell of the
    // square, column by column, and clear the message state. Returns the
    // number of cells queued.
    function automatic int transpose_predict(input logic [BYTE_W-1:0] b,
                                             input logic last);
        int    side;
        int    cap;
        int    pos;
        int    n;
        cell_t c;
        side = clamped_side(side_reg_copy);
        cap  = side * side;
        n    = 0;
        if (bytes_held < cap)
        begin
            grid_copy[bytes_held] = b;
            bytes_held++;
        end
        else
        begin
            spill_seen = 1'b1;
        end
        if (!last)
            return 0;
        for (int col = 0; col < side; col++)
        begin
            for (int row = 0; row < side; row++)
            begin
                pos    = row * side + col;
                c.data = (pos < bytes_held) ? grid_copy[pos] : BLANK_CELL;
                c.last = (n + 1 == cap);
                c.ovf  = spill_seen;
                expected_cells.push_back(c);
                n++;
            end
        end
        bytes_held = 0;
        spill_seen = 1'b0;
        return n;
    endfunction

    // Mostly short gaps, a few long ones, none in a steady phase
    function automatic int unsigned idle_cycles();
        int unsigned roll;
        if (steady_phase)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one byte and hold it until the transfer; predict at that edge.
    // Valid stays high afterwards so back-to-back bytes need no extra step.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                             output int produced);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        produced = transpose_predict(b, last);
        bytes_sent++;
        if (last)
            messages_sent++;
    endtask

    task automatic pause_sender();
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every queued cell has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
    endtask

    // Side writes happen only with the block idle
    task automatic write_side(input logic [CFG_W-1:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        side_reg_copy  = v;
        sides_written[v] = 1'b1;
    endtask

    task automatic send_message(input int unsigned len);
        int produced;
        for (int unsigned k = 0; k < len; k++)
        begin
            send_byte(BYTE_W'($urandom_range(0, 255)), k == len - 1, produced);
            pause_sender();
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_side();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return CFG_W'($urandom_range(1, 4));
        if (roll < 8)
            return CFG_W'($urandom_range(5, 8));
        return CFG_W'($urandom_range(0, 15));
    endfunction

    task automatic report_field(input string field, input logic [BYTE_W-1:0] want,
                                input logic [BYTE_W-1:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
    endtask

    // Sink: stall at random, mostly briefly; no new stall starts in a steady phase
    always @(posedge clk)
    begin : sink_ready
        int unsigned roll;
        if (sink_hold != 0)
        begin
            m_tready <= 1'b0;
            sink_hold--;
        end
        else if (steady_phase)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                m_tready <= 1'b1;
            end
            else if (roll < 96)
            begin
                m_tready  <= 1'b0;
                sink_hold  = $urandom_range(0, 3);
            end
            else
            begin
                m_tready  <= 1'b0;
                sink_hold  = $urandom_range(8, 30);
            end
        end
    end

    // Compare every cell transfer with the oldest expectation, field by field
    always @(posedge clk)
    begin : cell_check
        cell_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_cells.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected cell, expected none, actual %02h last %0b ovf %0b",
                         $time, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want = expected_cells.pop_front();
                cells_checked++;
                if (want.ovf)
                    spilled_cells++;
                if (m_tdata !== want.data)
                    report_field("out_byte", want.data, m_tdata);
                if (m_tlast !== want.last)
                    report_field("out_last", BYTE_W'(want.last), BYTE_W'(m_tlast));
                if (m_tuser !== want.ovf)
                    report_field("overflowed", BYTE_W'(want.ovf), BYTE_W'(m_tuser));
            end
        end
    end

    // Watchdog: end the run if nothing transfers for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d cells still expected",
                         $time, quiet_cycles, expected_cells.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t   row;
        int          produced;
        int unsigned random_bytes;
        int unsigned len;
        int unsigned cap;
        int unsigned roll;

        // Hold reset, then release it on an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes of side and byte, drops, blank cells
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_SIDE)
            begin
                write_side(row.value[CFG_W-1:0]);
            end
            else
            begin
                send_byte(row.value, row.last, produced);
                if (row.typed)
                begin
                    // replace the predicted cell with the one typed in the table
                    repeat (produced) void'(expected_cells.pop_back());
                    expected_cells.push_back(cell_t'{row.typed_byte, 1'b1, row.typed_ovf});
                end
                pause_sender();
            end
        end

        // Fill the largest square and spill over, closing byte included
        write_side(CFG_W'(MAX_SIDE));
        send_message(CELLS + 2);

        // Random messages: mostly fitting the square, some exact, some spilling
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 3) == 0)
                write_side(pick_side());
            else if ($urandom_range(0, 7) == 0)
                drain_results();
            steady_phase = ($urandom_range(0, 4) == 0);
            cap  = clamped_side(side_reg_copy) ** 2;
            roll = $urandom_range(0, 9);
            if (roll < 6)
                len = $urandom_range(1, cap);
            else if (roll < 8)
                len = cap;
            else
                len = cap + $urandom_range(1, 3);
            send_message(len);
            random_bytes += len;
        end
        steady_phase = 1'b0;

        // Let the last square out, then watch for stray cells
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d message bytes in %0d messages; %0d cells checked,",
                 bytes_sent, messages_sent, cells_checked);
        $display("%0d of them flagged overflowed; side values written (bit per value): %016b",
                 spilled_cells, sides_written);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
src/stb_pkg.sv
src/stb_ram.sv
src/stb_ctrl.sv
src/stb_datapath.sv
src/square_transposition_buffer.sv
dv/tb_square_transposition_buffer.sv
